/* hdl/retransmit_backoff_scheduler_defines.svh */
// assertion macros shared by the checker of the retransmit backoff scheduler
// expects signals clk and rst in the scope where a macro is used
`ifndef RETRANSMIT_BACKOFF_SCHEDULER_DEFINES_SVH
`define RETRANSMIT_BACKOFF_SCHEDULER_DEFINES_SVH

// same-cycle implication, off during reset
`define RBS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rbs assertion failed");

// next-cycle implication, off during reset
`define RBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rbs assertion failed");

`endif

/* hdl/rbs_pkg.sv */
// types and constants of the retransmit backoff scheduler
// no dependencies; used by the top level and its checker
package rbs_pkg;

  localparam int unsigned MAX_HOSTS = 64;
  localparam int unsigned SLOT_W    = $clog2(MAX_HOSTS);
  localparam int unsigned CNT_W     = SLOT_W + 1;

  localparam logic [15:0] PMAP_PORT     = 16'd111;
  localparam logic [6:0]  FRESH_RETRIES = 7'd100;
  localparam logic [6:0]  RETRY_SAT     = 7'd127;
  localparam logic [4:0]  BURST_CAP     = 5'd16;
  localparam logic [8:0]  HDR_WORDS     = 9'd6;
  localparam logic [8:0]  PMAP_WORDS    = 9'd7;

  // request codes
  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_REPLY = 2'd2;

  // result kinds
  localparam logic [3:0] K_QUERY    = 4'd0;
  localparam logic [3:0] K_NOTIFY   = 4'd1;
  localparam logic [3:0] K_NOTIFIED = 4'd2;
  localparam logic [3:0] K_IGNORED  = 4'd3;
  localparam logic [3:0] K_REQUEUED = 4'd4;
  localparam logic [3:0] K_ADDED    = 4'd5;
  localparam logic [3:0] K_REJECTED = 4'd6;
  localparam logic [3:0] K_TICKDONE = 4'd7;
  localparam logic [3:0] K_GAVEUP   = 4'd8;

  // register indexes
  localparam logic [2:0] CFG_MAX_TIMEOUT  = 3'd0;
  localparam logic [2:0] CFG_INIT_TIMEOUT = 3'd1;
  localparam logic [2:0] CFG_BURST_LIMIT  = 3'd2;
  localparam logic [2:0] CFG_GIVE_UP      = 3'd3;
  localparam logic [2:0] CFG_ROTATE       = 3'd4;
  localparam logic [2:0] CFG_XID_SEED     = 3'd5;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [5:0]  host_slot;
    logic [31:0] now;
    logic [31:0] last_used_time;
    logic [31:0] reply_xid;
    logic [15:0] reply_port;
    logic [8:0]  reply_words;
    logic        header_ok;
  } req_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [5:0]  slot_out;
    logic [31:0] xid_out;
    logic [15:0] dest_port;
    logic [31:0] next_due;
    logic [6:0]  pending_count;
    logic        last;
  } rsp_t;

  // one peer entry of the state memory
  typedef struct packed {
    logic [31:0] due;
    logic [31:0] stamp;
    logic [7:0]  ivl;
    logic [6:0]  cnt;
    logic [31:0] xid;
    logic [15:0] port;
  } peer_t;

endpackage

/* hdl/retransmit_backoff_scheduler.sv */
// retransmit backoff scheduler: one item at a time, 1..17 result items per item.
// add: a sorted scan over the queued entries, then a shift of the later ones.
// tick: each send removes the peer from the order and reinserts it by its new due time;
// a reply search checks the queued entries in order, walking the order memory.
// reset clears control state, configuration and queue bookkeeping; the peer and order
// memories are not cleared, no item is refused after reset.
module retransmit_backoff_scheduler (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  rbs_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output rbs_pkg::rsp_t rsp,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_EMIT    = 5'd1;
  localparam logic [4:0] S_ADD     = 5'd2;
  localparam logic [4:0] S_TK_GU   = 5'd3;
  localparam logic [4:0] S_TK_CHK  = 5'd4;
  localparam logic [4:0] S_TK_H1   = 5'd5;
  localparam logic [4:0] S_TK_H2   = 5'd6;
  localparam logic [4:0] S_TK_PROC = 5'd7;
  localparam logic [4:0] S_TK_FIN  = 5'd8;
  localparam logic [4:0] S_TK_F1   = 5'd9;
  localparam logic [4:0] S_TK_F2   = 5'd10;
  localparam logic [4:0] S_RP_SRCH = 5'd11;
  localparam logic [4:0] S_RP_S1   = 5'd12;
  localparam logic [4:0] S_RP_S2   = 5'd13;
  localparam logic [4:0] S_RP_PROC = 5'd14;
  localparam logic [4:0] S_EQ      = 5'd15;
  localparam logic [4:0] S_EQ1     = 5'd16;
  localparam logic [4:0] S_EQ2     = 5'd17;
  localparam logic [4:0] S_SH      = 5'd18;
  localparam logic [4:0] S_SH1     = 5'd19;
  localparam logic [4:0] S_RM      = 5'd20;
  localparam logic [4:0] S_RM1     = 5'd21;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_REPLY = 2'd2;

  localparam int unsigned SW = rbs_pkg::SLOT_W;
  localparam int unsigned CW = rbs_pkg::CNT_W;

  // configuration
  logic [7:0]  max_timeout, initial_timeout;
  logic [4:0]  burst_limit;
  logic [31:0] give_up_after, xid_seed;
  logic [6:0]  rotate_after_retries;

  // global state
  logic [CW-1:0]              total;
  logic [31:0]                xid_counter, deadline;
  logic                       deadline_set, given_up;
  logic [rbs_pkg::MAX_HOSTS-1:0] queued;

  // sequencer registers
  logic [4:0]          state, emit_next;
  logic [1:0]          op;
  rbs_pkg::req_t       req_r;
  rbs_pkg::peer_t      cur;
  logic [SW-1:0]       cur_slot;
  logic [CW-1:0]       i, j;
  logic [4:0]          sent;
  rbs_pkg::rsp_t       emit_item;
  rbs_pkg::rsp_t       rsp_load;

  // memories
  rbs_pkg::peer_t      peer_mem [rbs_pkg::MAX_HOSTS];
  logic [SW-1:0]       ord_mem  [rbs_pkg::MAX_HOSTS];
  rbs_pkg::peer_t      peer_rdata, peer_wdata;
  logic [SW-1:0]       peer_raddr, ord_raddr, ord_waddr, ord_wdata, ord_rdata;
  logic                peer_we, ord_we;

  logic [4:0]          burst;
  logic [31:0]         xid_draw;
  rbs_pkg::peer_t      tick_new, reply_new;
  logic [32:0]         sum_ivl, sum_max;
  logic [8:0]          dbl;
  logic [6:0]          cnt0;
  logic [7:0]          quarter;

  function automatic rbs_pkg::rsp_t mk(input logic [3:0] kind, input logic [5:0] slot,
                                       input logic [31:0] xid, input logic [15:0] port,
                                       input logic [31:0] due, input logic last);
    rbs_pkg::rsp_t r;
    r.kind          = kind;
    r.slot_out      = slot;
    r.xid_out       = xid;
    r.dest_port     = port;
    r.next_due      = due;
    r.pending_count = '0;
    r.last          = last;
    return r;
  endfunction

  assign req_stall = (state != S_IDLE);
  assign burst     = (burst_limit > rbs_pkg::BURST_CAP) ? rbs_pkg::BURST_CAP : burst_limit;
  assign xid_draw  = (xid_counter == 32'd0) ? xid_seed : xid_counter;
  assign quarter   = max_timeout >> 2;

  // result with the queue size at load time
  always_comb begin
    rsp_load               = emit_item;
    rsp_load.pending_count = total;
  end

  // backoff update of a popped peer
  always_comb begin
    sum_ivl  = {1'b0, req_r.now} + {25'd0, cur.ivl};
    dbl      = {cur.ivl, 1'b0};
    tick_new = cur;
    tick_new.xid = (cur.xid == 32'd0) ? xid_draw : cur.xid;
    cnt0 = cur.cnt;
    if (cur.cnt >= rotate_after_retries) begin
      tick_new.port = '0;
      cnt0 = '0;
    end
    tick_new.ivl = (dbl > {1'b0, max_timeout}) ? max_timeout : dbl[7:0];
    tick_new.due = sum_ivl[32] ? 32'hFFFF_FFFF : sum_ivl[31:0];
    tick_new.cnt = (cnt0 < rbs_pkg::RETRY_SAT) ? cnt0 + 7'd1 : cnt0;
  end

  // port-query reply update
  always_comb begin
    sum_max   = {1'b0, req_r.now} + {25'd0, max_timeout};
    reply_new = cur;
    if (req_r.reply_words >= rbs_pkg::PMAP_WORDS) begin
      reply_new.due = req_r.now;
      if (req_r.reply_port == 16'd0) begin
        reply_new.ivl = max_timeout;
        reply_new.due = sum_max[32] ? 32'hFFFF_FFFF : sum_max[31:0];
      end else begin
        reply_new.port = req_r.reply_port;
        if (cur.ivl >= quarter) reply_new.ivl = quarter;
      end
      reply_new.xid = '0;
    end
  end

  // memory port control
  always_comb begin
    peer_we    = 1'b0;
    peer_wdata = cur;
    peer_raddr = ord_rdata;
    ord_we     = 1'b0;
    ord_waddr  = j[SW-1:0];
    ord_wdata  = ord_rdata;
    ord_raddr  = '0;
    unique case (state)
      S_ADD:     peer_we = 1'b1;
      S_TK_PROC: begin
        peer_we    = 1'b1;
        peer_wdata = tick_new;
      end
      S_RP_PROC: begin
        peer_we    = (cur.port == 16'd0);
        peer_wdata = reply_new;
      end
      S_RP_SRCH, S_EQ: ord_raddr = i[SW-1:0];
      S_SH: begin
        ord_raddr = SW'(j - CW'(1));
        if (j <= i) begin
          ord_we    = 1'b1;
          ord_waddr = i[SW-1:0];
          ord_wdata = cur_slot;
        end
      end
      S_SH1, S_RM1: ord_we = 1'b1;
      S_RM: ord_raddr = SW'(j + CW'(1));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (peer_we) peer_mem[cur_slot] <= peer_wdata;
    peer_rdata <= peer_mem[peer_raddr];
    if (ord_we) ord_mem[ord_waddr] <= ord_wdata;
    ord_rdata <= ord_mem[ord_raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= S_IDLE;
      rsp_valid            <= 1'b0;
      max_timeout          <= 8'd120;
      initial_timeout      <= 8'd2;
      burst_limit          <= 5'd10;
      give_up_after        <= 32'd900;
      rotate_after_retries <= 7'd4;
      xid_seed             <= 32'd0;
      total                <= '0;
      xid_counter          <= '0;
      deadline             <= '0;
      deadline_set         <= 1'b0;
      given_up             <= 1'b0;
      queued               <= '0;
    end else begin
      // register writes
      if (cfg_we) begin
        unique case (cfg_index)
          rbs_pkg::CFG_MAX_TIMEOUT:  max_timeout          <= cfg_data[7:0];
          rbs_pkg::CFG_INIT_TIMEOUT: initial_timeout      <= cfg_data[7:0];
          rbs_pkg::CFG_BURST_LIMIT:  burst_limit          <= cfg_data[4:0];
          rbs_pkg::CFG_GIVE_UP:      give_up_after        <= cfg_data;
          rbs_pkg::CFG_ROTATE:       rotate_after_retries <= cfg_data[6:0];
          rbs_pkg::CFG_XID_SEED:     xid_seed             <= cfg_data;
          default: ;
        endcase
      end
      if (rsp_valid && !rsp_stall && state != S_EMIT) rsp_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            req_r <= req;
            emit_next <= S_IDLE;
            case (req.req_type)
              rbs_pkg::REQ_ADD: begin
                if (given_up || queued[req.host_slot] ||
                    total >= CW'(rbs_pkg::MAX_HOSTS)) begin
                  emit_item <= mk(rbs_pkg::K_REJECTED, req.host_slot, '0, '0, '0, 1'b1);
                  state     <= S_EMIT;
                end else begin
                  cur.due   <= '0;
                  cur.stamp <= req.last_used_time;
                  cur.ivl   <= initial_timeout;
                  cur.cnt   <= rbs_pkg::FRESH_RETRIES;
                  cur.xid   <= '0;
                  cur.port  <= '0;
                  cur_slot  <= req.host_slot;
                  op        <= OP_ADD;
                  i         <= '0;
                  state     <= S_ADD;
                end
              end
              rbs_pkg::REQ_TICK: begin
                if (!deadline_set) begin
                  deadline_set <= 1'b1;
                  if (give_up_after == 32'd0) deadline <= '0;
                  else if ({1'b0, req.now} + {1'b0, give_up_after} > 33'h0_FFFF_FFFF)
                    deadline <= 32'hFFFF_FFFF;
                  else deadline <= req.now + give_up_after;
                end
                op    <= OP_TICK;
                state <= S_TK_GU;
              end
              rbs_pkg::REQ_REPLY: begin
                if (given_up || !req.header_ok || req.reply_words < rbs_pkg::HDR_WORDS ||
                    req.reply_xid == 32'd0) begin
                  emit_item <= mk(rbs_pkg::K_IGNORED, '0, req.reply_xid, '0, '0, 1'b1);
                  state     <= S_EMIT;
                end else begin
                  op    <= OP_REPLY;
                  i     <= '0;
                  state <= S_RP_SRCH;
                end
              end
              default: begin
                emit_item <= mk(rbs_pkg::K_IGNORED, '0, '0, '0, '0, 1'b1);
                state     <= S_EMIT;
              end
            endcase
          end
        end

        // result register load
        S_EMIT: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp       <= rsp_load;
            rsp_valid <= 1'b1;
            state     <= emit_next;
          end
        end

        S_ADD: state <= S_EQ;

        // deadline check
        S_TK_GU: begin
          if (given_up || (total != '0 && deadline != 32'd0 && req_r.now >= deadline)) begin
            given_up  <= 1'b1;
            total     <= '0;
            queued    <= '0;
            emit_item <= mk(rbs_pkg::K_GAVEUP, '0, '0, '0, '0, 1'b1);
            emit_next <= S_IDLE;
            state     <= S_EMIT;
          end else begin
            sent  <= '0;
            state <= S_TK_CHK;
          end
        end

        S_TK_CHK: begin
          if (total != '0 && sent < burst) state <= S_TK_H1;
          else state <= S_TK_FIN;
        end
        S_TK_H1: begin
          cur_slot <= ord_rdata;
          state    <= S_TK_H2;
        end
        S_TK_H2: begin
          if (peer_rdata.due <= req_r.now) begin
            cur   <= peer_rdata;
            j     <= '0;
            state <= S_RM;
          end else begin
            emit_item <= mk(rbs_pkg::K_TICKDONE, cur_slot, '0, '0, peer_rdata.due, 1'b1);
            emit_next <= S_IDLE;
            state     <= S_EMIT;
          end
        end
        S_TK_PROC: begin
          if (cur.xid == 32'd0) xid_counter <= xid_draw + 32'd1;
          cur   <= tick_new;
          i     <= '0;
          state <= S_EQ;
        end
        S_TK_FIN: begin
          if (total == '0) begin
            emit_item <= mk(rbs_pkg::K_TICKDONE, '0, '0, '0, '0, 1'b1);
            emit_next <= S_IDLE;
            state     <= S_EMIT;
          end else begin
            state <= S_TK_F1;
          end
        end
        S_TK_F1: begin
          cur_slot <= ord_rdata;
          state    <= S_TK_F2;
        end
        S_TK_F2: begin
          emit_item <= mk(rbs_pkg::K_TICKDONE, cur_slot, '0, '0, peer_rdata.due, 1'b1);
          emit_next <= S_IDLE;
          state     <= S_EMIT;
        end

        // xid search through the queue
        S_RP_SRCH: begin
          if (i < total) begin
            state <= S_RP_S1;
          end else begin
            emit_item <= mk(rbs_pkg::K_IGNORED, '0, req_r.reply_xid, '0, '0, 1'b1);
            emit_next <= S_IDLE;
            state     <= S_EMIT;
          end
        end
        S_RP_S1: begin
          cur_slot <= ord_rdata;
          state    <= S_RP_S2;
        end
        S_RP_S2: begin
          if (peer_rdata.xid == req_r.reply_xid) begin
            cur   <= peer_rdata;
            j     <= i;
            state <= S_RM;
          end else begin
            i     <= i + CW'(1);
            state <= S_RP_SRCH;
          end
        end
        S_RP_PROC: begin
          if (cur.port != 16'd0) begin
            emit_item <= mk(rbs_pkg::K_NOTIFIED, cur_slot, req_r.reply_xid, cur.port, '0,
                            1'b1);
            emit_next <= S_IDLE;
            state     <= S_EMIT;
          end else begin
            cur   <= reply_new;
            i     <= '0;
            state <= S_EQ;
          end
        end

        // sorted insertion scan
        S_EQ: begin
          if (i < total) begin
            state <= S_EQ1;
          end else begin
            j     <= total;
            state <= S_SH;
          end
        end
        S_EQ1: state <= S_EQ2;
        S_EQ2: begin
          if (cur.due < peer_rdata.due ||
              (cur.due == peer_rdata.due && cur.stamp > peer_rdata.stamp)) begin
            j     <= total;
            state <= S_SH;
          end else begin
            i     <= i + CW'(1);
            state <= S_EQ;
          end
        end
        S_SH: begin
          if (j > i) begin
            state <= S_SH1;
          end else begin
            total            <= total + CW'(1);
            queued[cur_slot] <= 1'b1;
            state            <= S_EMIT;
            case (op)
              OP_ADD: begin
                emit_item <= mk(rbs_pkg::K_ADDED, cur_slot, '0, '0, '0, 1'b1);
                emit_next <= S_IDLE;
              end
              OP_TICK: begin
                sent <= sent + 5'd1;
                if (cur.port == 16'd0)
                  emit_item <= mk(rbs_pkg::K_QUERY, cur_slot, cur.xid, rbs_pkg::PMAP_PORT,
                                  '0, 1'b0);
                else
                  emit_item <= mk(rbs_pkg::K_NOTIFY, cur_slot, cur.xid, cur.port, '0, 1'b0);
                emit_next <= S_TK_CHK;
              end
              default: begin
                emit_item <= mk(rbs_pkg::K_REQUEUED, cur_slot, req_r.reply_xid, cur.port,
                                cur.due, 1'b1);
                emit_next <= S_IDLE;
              end
            endcase
          end
        end
        S_SH1: begin
          j     <= j - CW'(1);
          state <= S_SH;
        end

        // removal, closing the gap
        S_RM: begin
          if (j + CW'(1) < total) begin
            state <= S_RM1;
          end else begin
            total            <= total - CW'(1);
            queued[cur_slot] <= 1'b0;
            state            <= (op == OP_TICK) ? S_TK_PROC : S_RP_PROC;
          end
        end
        S_RM1: begin
          j     <= j + CW'(1);
          state <= S_RM;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/rbs_checker.sv */
// port-level checker for the retransmit backoff scheduler, bound to the top level
// depends on rbs_pkg and retransmit_backoff_scheduler_defines.svh
`include "retransmit_backoff_scheduler_defines.svh"

module rbs_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input rbs_pkg::rsp_t rsp
);

  // a held result item keeps its value
  `RBS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

  // an accepted item blocks intake until its last result is loaded
  `RBS_ASSERT_NEXT(a_one_item, req_valid && !req_stall, req_stall)

  // sends are never the final result of a tick
  `RBS_ASSERT_NOW(a_send_not_last,
    rsp_valid && (rsp.kind == rbs_pkg::K_QUERY || rsp.kind == rbs_pkg::K_NOTIFY), !rsp.last)

  // give-up leaves an empty queue and closes the item
  `RBS_ASSERT_NOW(a_gaveup_empty, rsp_valid && rsp.kind == rbs_pkg::K_GAVEUP,
    rsp.pending_count == 7'd0 && rsp.last)

endmodule

bind retransmit_backoff_scheduler rbs_checker u_rbs_checker (.*);
